>>> hw/rtl/wsp_pkg.sv
// Shared types and codes for the WAV stream peak meter.
`timescale 1ns / 1ps
package wsp_pkg;

   localparam int MaxChannels   = 64;
   localparam int ShownChannels = 2;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [14:0] PEAK_CLAMP  = 15'd32767;
   localparam logic [15:0] MARK_EVERY  = 16'd20;
   localparam logic [15:0] BITS_OK     = 16'd16;
   localparam logic [7:0]  SCALE_RESET = 8'd10;

   localparam logic [1:0] KIND_WINDOW  = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NO_RIFF   = 3'd1;
   localparam logic [2:0] ERR_NO_WAVE   = 3'd2;
   localparam logic [2:0] ERR_HEADER    = 3'd3;
   localparam logic [2:0] ERR_NO_FMT    = 3'd4;
   localparam logic [2:0] ERR_BITS      = 3'd5;
   localparam logic [2:0] ERR_CHANNELS  = 3'd6;
   localparam logic [2:0] ERR_TRUNCATED = 3'd7;

   // tdata bit positions of the result word
   localparam int RSP_DATA_W = 80;
   localparam int MARK_BIT   = 40;
   localparam int ERR_LO     = 41;

   typedef struct packed {
      logic [1:0]  kind;
      logic        channel;
      logic [14:0] peak;
      logic [7:0]  bar_length;
      logic [15:0] column;
      logic        time_mark;
      logic [2:0]  error_code;
      logic [30:0] total_frames;
      logic        last;
   } result_type;

   function automatic result_type make_result(
      input logic [1:0]  kind,
      input logic        channel,
      input logic [14:0] peak,
      input logic [7:0]  bar_scale,
      input logic [15:0] column,
      input logic        time_mark,
      input logic [2:0]  error_code,
      input logic [30:0] total_frames
   );
      result_type r;
      logic [22:0] prod;
      prod = 23'(peak) * 23'(bar_scale);
      r.kind         = kind;
      r.channel      = channel;
      r.peak         = peak;
      r.bar_length   = prod[22:15];
      r.column       = column;
      r.time_mark    = time_mark;
      r.error_code   = error_code;
      r.total_frames = total_frames;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

>>> hw/rtl/wav_stream_peak_meter_core.sv
// The results of a byte show on rsp in the cycle after the byte is taken.
// One byte per cycle when rsp is not stalled; a byte that causes several results holds
// req until the last of them is being handed out through the 4-entry result buffer.
// Reset (synchronous, active high) returns the parser to expecting the RIFF tag,
// empties the result buffer and sets bar_scale to 10.
`timescale 1ns / 1ps
module wav_stream_peak_meter_core
   import wsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // in_byte
   input  logic                  req_tlast,   // end_of_file
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // channel[0], peak[15:1], bar_length[23:16], column[39:24], time_mark[40],
   // error_code[43:41], total_frames[74:44], zero fill [79:75]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,   // kind
   output logic                  rsp_tlast    // last
);

   localparam logic [3:0] PH_RIFF     = 4'd0;
   localparam logic [3:0] PH_RSIZE    = 4'd1;
   localparam logic [3:0] PH_WAVE     = 4'd2;
   localparam logic [3:0] PH_ID       = 4'd3;
   localparam logic [3:0] PH_SZ_FMT   = 4'd4;
   localparam logic [3:0] PH_SZ_DATA  = 4'd5;
   localparam logic [3:0] PH_SZ_OTHER = 4'd6;
   localparam logic [3:0] PH_FMT      = 4'd7;
   localparam logic [3:0] PH_DATA     = 4'd8;
   localparam logic [3:0] PH_SKIP     = 4'd9;
   localparam logic [3:0] PH_PAD      = 4'd10;
   localparam logic [3:0] PH_HALT     = 4'd11;

   logic [7:0]  scale_ff;
   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  bif_ff, bif_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] fmt_off_ff, fmt_off_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic [15:0] chans_ff, chans_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] rate_ff, rate_in;
   logic [5:0]  ch_idx_ff, ch_idx_in;
   logic [31:0] win_frames_ff, win_frames_in;
   logic [15:0] win_col_ff, win_col_in;
   logic [4:0]  mark_cnt_ff, mark_cnt_in;
   logic [15:0] win_peak_ff [2];
   logic [15:0] win_peak_in [2];
   logic [14:0] ovr_peak_ff [2];
   logic [14:0] ovr_peak_in [2];
   logic [30:0] frames_ff, frames_in;
   logic        odd_ff, odd_in;

   result_type  res_ff [4];
   result_type  res_in [4];
   logic [2:0]  res_n;
   logic [2:0]  cnt_ff;
   logic [1:0]  rd_ff;

   logic        fire_in, fire_out;

   assign req_tready = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_tready);
   assign fire_in    = req_tvalid && req_tready;
   assign fire_out   = rsp_tvalid && rsp_tready;

   always_comb begin
      logic [7:0]  b;
      logic [1:0]  shown;
      logic        body;
      logic        close;
      logic [15:0] v;
      logic [15:0] a;
      logic [14:0] p;
      logic [1:0]  sum_cnt;

      b        = req_tdata;
      body     = 1'b0;
      close    = 1'b0;
      p        = '0;
      sum_cnt  = '0;
      res_n    = 3'd0;
      for (int k = 0; k < 4; k++) begin
         res_in[k] = res_ff[k];
      end

      phase_in      = phase_ff;
      bif_in        = bif_ff;
      word_in       = word_ff;
      remain_in     = remain_ff;
      fmt_off_in    = fmt_off_ff;
      fmt_seen_in   = fmt_seen_ff;
      chans_in      = chans_ff;
      bits_in       = bits_ff;
      rate_in       = rate_ff;
      ch_idx_in     = ch_idx_ff;
      win_frames_in = win_frames_ff;
      win_col_in    = win_col_ff;
      mark_cnt_in   = mark_cnt_ff;
      win_peak_in   = win_peak_ff;
      ovr_peak_in   = ovr_peak_ff;
      frames_in     = frames_ff;
      odd_in        = odd_ff;

      shown = (chans_ff >= 16'd2) ? 2'd2 : chans_ff[1:0];
      v     = {b, word_ff[7:0]};
      a     = v[15] ? (16'd0 - v) : v;

      case (phase_ff)
         PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
            word_in = {b, word_ff[31:8]};
            bif_in  = bif_ff + 3'd1;
            if (bif_ff == 3'd3) begin
               bif_in = 3'd0;
               case (phase_ff)
                  PH_RIFF: begin
                     if (word_in != TAG_RIFF) begin
                        res_in[res_n[1:0]] = make_result(KIND_ERROR, 1'b0, '0, scale_ff, '0,
                                                         1'b0, ERR_NO_RIFF, '0);
                        res_n    = res_n + 3'd1;
                        phase_in = PH_HALT;
                     end else begin
                        phase_in = PH_RSIZE;
                     end
                  end
                  PH_RSIZE: phase_in = PH_WAVE;
                  PH_WAVE: begin
                     if (word_in != TAG_WAVE) begin
                        res_in[res_n[1:0]] = make_result(KIND_ERROR, 1'b0, '0, scale_ff, '0,
                                                         1'b0, ERR_NO_WAVE, '0);
                        res_n    = res_n + 3'd1;
                        phase_in = PH_HALT;
                     end else begin
                        phase_in = PH_ID;
                     end
                  end
                  PH_ID: begin
                     if (word_in == TAG_FMT)
                        phase_in = PH_SZ_FMT;
                     else if (word_in == TAG_DATA)
                        phase_in = PH_SZ_DATA;
                     else
                        phase_in = PH_SZ_OTHER;
                  end
                  default: begin
                     // chunk size complete
                     remain_in = word_in;
                     odd_in    = word_in[0];
                     if (phase_ff == PH_SZ_FMT) begin
                        fmt_off_in = '0;
                        phase_in   = PH_FMT;
                        if (word_in == '0) begin
                           fmt_seen_in = 1'b1;
                           phase_in    = word_in[0] ? PH_PAD : PH_ID;
                        end
                     end else if (phase_ff == PH_SZ_DATA) begin
                        if (!fmt_seen_ff) begin
                           res_in[res_n[1:0]] = make_result(KIND_ERROR, 1'b0, '0, scale_ff,
                                                            '0, 1'b0, ERR_NO_FMT, '0);
                           res_n    = res_n + 3'd1;
                           phase_in = PH_HALT;
                        end else if (bits_ff != BITS_OK) begin
                           res_in[res_n[1:0]] = make_result(KIND_ERROR, 1'b0, '0, scale_ff,
                                                            '0, 1'b0, ERR_BITS, '0);
                           res_n    = res_n + 3'd1;
                           phase_in = PH_HALT;
                        end else if (chans_ff == '0 || chans_ff >= 16'(MaxChannels)) begin
                           res_in[res_n[1:0]] = make_result(KIND_ERROR, 1'b0, '0, scale_ff,
                                                            '0, 1'b0, ERR_CHANNELS, '0);
                           res_n    = res_n + 3'd1;
                           phase_in = PH_HALT;
                        end else begin
                           ch_idx_in      = '0;
                           bif_in         = '0;
                           win_frames_in  = '0;
                           win_col_in     = '0;
                           mark_cnt_in    = '0;
                           win_peak_in[0] = '0;
                           win_peak_in[1] = '0;
                           frames_in      = '0;
                           phase_in       = PH_DATA;
                           if (word_in == '0) phase_in = PH_ID;
                        end
                     end else begin
                        phase_in = PH_SKIP;
                        if (word_in == '0) phase_in = word_in[0] ? PH_PAD : PH_ID;
                     end
                  end
               endcase
            end
         end
         PH_FMT: begin
            word_in = {b, word_ff[31:8]};
            if (fmt_off_ff == 32'd3)
               chans_in = word_in[31:16];
            else if (fmt_off_ff == 32'd7)
               rate_in = word_in;
            else if (fmt_off_ff == 32'd15)
               bits_in = word_in[31:16];
            if (fmt_off_ff != '1) fmt_off_in = fmt_off_ff + 32'd1;
            body = 1'b1;
         end
         PH_DATA: begin
            if (ch_idx_ff == '0 && bif_ff == '0 && remain_ff < {15'd0, chans_ff, 1'b0}) begin
               // too short for a whole frame: skip the rest
               phase_in = PH_SKIP;
            end else if (bif_ff == '0) begin
               word_in = {24'd0, b};
               bif_in  = 3'd1;
            end else begin
               for (int i = 0; i < ShownChannels; i++) begin
                  if (ch_idx_ff == 6'(i) && win_peak_ff[i] < a) win_peak_in[i] = a;
               end
               bif_in    = '0;
               ch_idx_in = ch_idx_ff + 6'd1;
               if (16'(ch_idx_in) >= chans_ff) begin
                  ch_idx_in = '0;
                  if (frames_ff != '1) frames_in = frames_ff + 31'd1;
                  win_frames_in = win_frames_ff + 32'd1;
                  if (win_frames_in >= (rate_ff >> 1)) close = 1'b1;
               end
            end
            body = 1'b1;
         end
         PH_SKIP: body = 1'b1;
         PH_PAD:  phase_in = PH_ID;
         default: ;
      endcase

      if (close) begin
         for (int i = 0; i < ShownChannels; i++) begin
            if (2'(i) < shown) begin
               p = (win_peak_in[i] > 16'(PEAK_CLAMP)) ? PEAK_CLAMP : win_peak_in[i][14:0];
               if (ovr_peak_in[i] < p) ovr_peak_in[i] = p;
               // mark_cnt tracks column mod 20
               res_in[res_n[1:0]] = make_result(KIND_WINDOW, 1'(i), p, scale_ff, win_col_ff,
                                                mark_cnt_ff == '0, ERR_NONE, '0);
               res_n          = res_n + 3'd1;
               win_peak_in[i] = '0;
            end
         end
         win_frames_in = '0;
         if (win_col_ff != '1) begin
            win_col_in  = win_col_ff + 16'd1;
            mark_cnt_in = (mark_cnt_ff == 5'(MARK_EVERY - 16'd1)) ? '0 : mark_cnt_ff + 5'd1;
         end
      end

      if (body) begin
         if (remain_ff != '0) remain_in = remain_ff - 32'd1;
         if (remain_in == '0) begin
            if (phase_ff == PH_FMT) fmt_seen_in = 1'b1;
            phase_in = odd_ff ? PH_PAD : PH_ID;
         end
      end

      if (req_tlast) begin
         if (phase_in == PH_ID || phase_in == PH_PAD) begin
            // channel count as updated by this byte
            sum_cnt = (chans_in >= 16'd2) ? 2'd2 : (chans_in == '0) ? 2'd1 : chans_in[1:0];
            for (int i = 0; i < ShownChannels; i++) begin
               if (2'(i) < sum_cnt) begin
                  res_in[res_n[1:0]] = make_result(KIND_SUMMARY, 1'(i), ovr_peak_in[i],
                                                   scale_ff, win_col_in, 1'b0, ERR_NONE,
                                                   frames_in);
                  res_n = res_n + 3'd1;
               end
            end
         end else if (phase_in != PH_HALT) begin
            res_in[res_n[1:0]] = make_result(KIND_ERROR, 1'b0, '0, scale_ff, '0, 1'b0,
               (phase_in == PH_RIFF) ? ERR_NO_RIFF :
               (phase_in == PH_RSIZE || phase_in == PH_WAVE) ? ERR_NO_WAVE :
               (phase_in >= PH_SZ_FMT && phase_in <= PH_SZ_OTHER) ? ERR_HEADER :
               ERR_TRUNCATED, '0);
            res_n = res_n + 3'd1;
         end
         phase_in       = PH_RIFF;
         bif_in         = '0;
         word_in        = '0;
         remain_in      = '0;
         fmt_off_in     = '0;
         fmt_seen_in    = 1'b0;
         chans_in       = '0;
         bits_in        = '0;
         rate_in        = '0;
         ch_idx_in      = '0;
         win_frames_in  = '0;
         win_col_in     = '0;
         mark_cnt_in    = '0;
         win_peak_in[0] = '0;
         win_peak_in[1] = '0;
         ovr_peak_in[0] = '0;
         ovr_peak_in[1] = '0;
         frames_in      = '0;
         odd_in         = 1'b0;
      end

      if (res_n != '0) res_in[2'(res_n - 3'd1)].last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff       <= SCALE_RESET;
         phase_ff       <= PH_RIFF;
         bif_ff         <= '0;
         word_ff        <= '0;
         remain_ff      <= '0;
         fmt_off_ff     <= '0;
         fmt_seen_ff    <= 1'b0;
         chans_ff       <= '0;
         bits_ff        <= '0;
         rate_ff        <= '0;
         ch_idx_ff      <= '0;
         win_frames_ff  <= '0;
         win_col_ff     <= '0;
         mark_cnt_ff    <= '0;
         win_peak_ff[0] <= '0;
         win_peak_ff[1] <= '0;
         ovr_peak_ff[0] <= '0;
         ovr_peak_ff[1] <= '0;
         frames_ff      <= '0;
         odd_ff         <= 1'b0;
         cnt_ff         <= '0;
         rd_ff          <= '0;
      end else begin
         if (csr_wr_en) scale_ff <= csr_wr_data;
         if (fire_in) begin
            phase_ff      <= phase_in;
            bif_ff        <= bif_in;
            word_ff       <= word_in;
            remain_ff     <= remain_in;
            fmt_off_ff    <= fmt_off_in;
            fmt_seen_ff   <= fmt_seen_in;
            chans_ff      <= chans_in;
            bits_ff       <= bits_in;
            rate_ff       <= rate_in;
            ch_idx_ff     <= ch_idx_in;
            win_frames_ff <= win_frames_in;
            win_col_ff    <= win_col_in;
            mark_cnt_ff   <= mark_cnt_in;
            win_peak_ff   <= win_peak_in;
            ovr_peak_ff   <= ovr_peak_in;
            frames_ff     <= frames_in;
            odd_ff        <= odd_in;
         end
         if (fire_in && res_n != '0) begin
            cnt_ff <= res_n;
            rd_ff  <= '0;
         end else if (fire_out) begin
            cnt_ff <= cnt_ff - 3'd1;
            rd_ff  <= rd_ff + 2'd1;
         end
      end
   end

   // result buffer payload
   always_ff @(posedge clock) begin
      if (fire_in && res_n != '0) res_ff <= res_in;
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tuser  = res_ff[rd_ff].kind;
   assign rsp_tlast  = res_ff[rd_ff].last;
   assign rsp_tdata  = {5'd0, res_ff[rd_ff].total_frames, res_ff[rd_ff].error_code,
                        res_ff[rd_ff].time_mark, res_ff[rd_ff].column,
                        res_ff[rd_ff].bar_length, res_ff[rd_ff].peak,
                        res_ff[rd_ff].channel};

endmodule

>>> hw/rtl/wsp_checker.sv
// Port-level checks for the peak meter and their binding.
`timescale 1ns / 1ps
module wsp_checker
   import wsp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("bad result kind");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |-> rsp_tlast && rsp_tdata[15:1] == '0)
      else $error("error word malformed");

   a_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_WINDOW |-> !rsp_tdata[MARK_BIT])
      else $error("time mark outside window word");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken with results pending");

endmodule

bind wav_stream_peak_meter_core wsp_checker u_wsp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/wav_stream_peak_meter_core_tb.sv
// Testbench for the WAV stream peak meter: scripted WAV files with an in-bench predictor.
`timescale 1ns / 1ps
module wav_stream_peak_meter_core_tb;
   import wsp_pkg::*;

   typedef enum int {
      P_RIFF, P_RSIZE, P_WAVE, P_ID, P_SZ_FMT, P_SZ_DATA, P_SZ_OTHER,
      P_FMT, P_DATA, P_SKIP, P_PAD, P_HALT
   } parse_phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [7:0]            csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;

   wav_stream_peak_meter_core dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // meter state as the block should hold it
   logic [7:0]      m_scale;
   parse_phase_type m_phase;
   logic [2:0]      m_nbyte;
   logic [31:0]     m_word, m_remaining, m_fmt_off, m_rate, m_win_frames;
   logic            m_fmt_seen, m_odd;
   logic [15:0]     m_chans, m_bits, m_column;
   logic [5:0]      m_chan_idx;
   logic [16:0]     m_win_peak [2];
   logic [14:0]     m_all_peak [2];
   logic [30:0]     m_frames;

   result_type peak_q[$];
   logic [7:0] file_q[$];
   int         fail_count = 0;
   int         burst_left = 0;

   function automatic void clear_meter();
      m_phase = P_RIFF; m_nbyte = 0; m_word = 0; m_remaining = 0; m_fmt_off = 0;
      m_fmt_seen = 0; m_chans = 0; m_bits = 0; m_rate = 0; m_chan_idx = 0;
      m_win_frames = 0; m_column = 0; m_win_peak[0] = 0; m_win_peak[1] = 0;
      m_all_peak[0] = 0; m_all_peak[1] = 0; m_frames = 0; m_odd = 0;
   endfunction

   function automatic void push_peak(logic [1:0] kind, logic ch, logic [14:0] pk,
                                     logic [15:0] col, logic mark, logic [2:0] err,
                                     logic [30:0] frames);
      result_type r;
      logic [22:0] prod;
      prod = pk * m_scale;
      r.kind = kind; r.channel = ch; r.peak = pk; r.bar_length = prod >> 15;
      r.column = col; r.time_mark = mark; r.error_code = err;
      r.total_frames = frames; r.last = 1'b0;
      peak_q.push_back(r);
   endfunction

   function automatic void halt_meter(logic [2:0] err);
      push_peak(KIND_ERROR, 0, 0, 0, 0, err, 0);
      m_phase = P_HALT;
   endfunction

   function automatic int shown();
      return (m_chans < 2) ? int'(m_chans) : 2;
   endfunction

   function automatic void chunk_done();
      m_phase = m_odd ? P_PAD : P_ID;
   endfunction

   function automatic void body_taken();
      if (m_remaining > 0) m_remaining--;
      if (m_remaining == 0) begin
         if (m_phase == P_FMT) m_fmt_seen = 1;
         chunk_done();
      end
   endfunction

   function automatic void close_window();
      logic [14:0] p;
      for (int i = 0; i < shown(); i++) begin
         p = (m_win_peak[i] > 17'd32767) ? PEAK_CLAMP : m_win_peak[i][14:0];
         if (m_all_peak[i] < p) m_all_peak[i] = p;
         push_peak(KIND_WINDOW, i[0], p, m_column, (m_column % 20) == 0, ERR_NONE, 0);
         m_win_peak[i] = 0;
      end
      m_win_frames = 0;
      if (m_column != 16'hFFFF) m_column++;
   endfunction

   function automatic void sample_byte(logic [7:0] b);
      logic [15:0] v;
      logic [16:0] mag;
      if (m_nbyte == 0) begin
         m_word = b;
         m_nbyte = 1;
      end else begin
         v = {b, m_word[7:0]};
         mag = v[15] ? 17'h10000 - v : {1'b0, v};
         if (m_chan_idx < 2 && m_win_peak[m_chan_idx] < mag) m_win_peak[m_chan_idx] = mag;
         m_nbyte = 0;
         m_chan_idx++;
         if (m_chan_idx >= m_chans) begin
            m_chan_idx = 0;
            if (m_frames != 31'h7FFFFFFF) m_frames++;
            m_win_frames++;
            if (m_win_frames >= (m_rate >> 1)) close_window();
         end
      end
      body_taken();
   endfunction

   function automatic void size_taken(logic [31:0] w);
      m_remaining = w;
      m_odd = w[0];
      if (m_phase == P_SZ_FMT) begin
         m_fmt_off = 0;
         m_phase = P_FMT;
         if (w == 0) begin
            m_fmt_seen = 1;
            chunk_done();
         end
      end else if (m_phase == P_SZ_DATA) begin
         if (!m_fmt_seen) halt_meter(ERR_NO_FMT);
         else if (m_bits != BITS_OK) halt_meter(ERR_BITS);
         else if (m_chans == 0 || m_chans >= MaxChannels) halt_meter(ERR_CHANNELS);
         else begin
            m_chan_idx = 0; m_nbyte = 0; m_win_frames = 0; m_column = 0;
            m_win_peak[0] = 0; m_win_peak[1] = 0; m_frames = 0;
            m_phase = P_DATA;
            if (w == 0) chunk_done();
         end
      end else begin
         m_phase = P_SKIP;
         if (w == 0) chunk_done();
      end
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic eof);
      int q_start;
      int s;
      q_start = peak_q.size();
      case (m_phase)
         P_RIFF, P_RSIZE, P_WAVE, P_ID, P_SZ_FMT, P_SZ_DATA, P_SZ_OTHER: begin
            m_word = {b, m_word[31:8]};
            m_nbyte++;
            if (m_nbyte == 4) begin
               m_nbyte = 0;
               case (m_phase)
                  P_RIFF:  if (m_word != TAG_RIFF) halt_meter(ERR_NO_RIFF);
                           else m_phase = P_RSIZE;
                  P_RSIZE: m_phase = P_WAVE;
                  P_WAVE:  if (m_word != TAG_WAVE) halt_meter(ERR_NO_WAVE);
                           else m_phase = P_ID;
                  P_ID:    m_phase = (m_word == TAG_FMT) ? P_SZ_FMT :
                                     (m_word == TAG_DATA) ? P_SZ_DATA : P_SZ_OTHER;
                  default: size_taken(m_word);
               endcase
            end
         end
         P_FMT: begin
            m_word = {b, m_word[31:8]};
            if (m_fmt_off == 3) m_chans = m_word[31:16];
            else if (m_fmt_off == 7) m_rate = m_word;
            else if (m_fmt_off == 15) m_bits = m_word[31:16];
            if (m_fmt_off != 32'hFFFFFFFF) m_fmt_off++;
            body_taken();
         end
         P_DATA: begin
            // tail too short for a whole frame is skipped
            if (m_chan_idx == 0 && m_nbyte == 0 && m_remaining < 2 * m_chans) begin
               m_phase = P_SKIP;
               body_taken();
            end else sample_byte(b);
         end
         P_SKIP: body_taken();
         P_PAD:  m_phase = P_ID;
         default: ;
      endcase
      if (eof) begin
         if (m_phase == P_ID || m_phase == P_PAD) begin
            s = (shown() == 0) ? 1 : shown();
            for (int i = 0; i < s; i++)
               push_peak(KIND_SUMMARY, i[0], m_all_peak[i], m_column, 0, ERR_NONE, m_frames);
         end else if (m_phase == P_RIFF) halt_meter(ERR_NO_RIFF);
         else if (m_phase == P_RSIZE || m_phase == P_WAVE) halt_meter(ERR_NO_WAVE);
         else if (m_phase >= P_SZ_FMT && m_phase <= P_SZ_OTHER) halt_meter(ERR_HEADER);
         else if (m_phase != P_HALT) halt_meter(ERR_TRUNCATED);
         clear_meter();
      end
      if (peak_q.size() > q_start) peak_q[peak_q.size() - 1].last = 1'b1;
   endfunction

   // result checker
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (peak_q.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            e = peak_q.pop_front();
            if (rsp_tuser != e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp_tuser); fail_count++;
            end
            if (rsp_tdata[0] != e.channel) begin
               $error("channel: expected %0d, got %0d", e.channel, rsp_tdata[0]); fail_count++;
            end
            if (rsp_tdata[15:1] != e.peak) begin
               $error("peak: expected %0d, got %0d", e.peak, rsp_tdata[15:1]); fail_count++;
            end
            if (rsp_tdata[23:16] != e.bar_length) begin
               $error("bar_length: expected %0d, got %0d", e.bar_length, rsp_tdata[23:16]);
               fail_count++;
            end
            if (rsp_tdata[39:24] != e.column) begin
               $error("column: expected %0d, got %0d", e.column, rsp_tdata[39:24]);
               fail_count++;
            end
            if (rsp_tdata[MARK_BIT] != e.time_mark) begin
               $error("time_mark: expected %0d, got %0d", e.time_mark, rsp_tdata[MARK_BIT]);
               fail_count++;
            end
            if (rsp_tdata[ERR_LO+:3] != e.error_code) begin
               $error("error_code: expected %0d, got %0d", e.error_code, rsp_tdata[ERR_LO+:3]);
               fail_count++;
            end
            if (rsp_tdata[74:44] != e.total_frames) begin
               $error("total_frames: expected %0d, got %0d", e.total_frames, rsp_tdata[74:44]);
               fail_count++;
            end
            if (rsp_tlast != e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_tlast); fail_count++;
            end
         end
      end
   end

   // receiver stalls: a random mode is picked each time stall_cnt wraps to 0, mode 0 never stalls
   int stall_mode = 0;
   int stall_cnt = 0;
   always @(negedge clock) begin
      if (stall_cnt == 0) stall_mode = $urandom_range(0, 3);
      stall_cnt = (stall_cnt + 1) % 50;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 1) != 0);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send_byte(input logic [7:0] b, input logic eof);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 5)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
      predict_byte(b, eof);
      burst_left--;
   endtask

   task automatic send_file();
      for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
      file_q.delete();
   endtask

   // wait for the block to go quiet, then write bar_scale
   task automatic write_scale(input logic [7:0] v);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (peak_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      m_scale = v;
   endtask

   function automatic void add_le(logic [31:0] v, int nbytes);
      for (int i = 0; i < nbytes; i++) file_q.push_back(v[8*i+:8]);
   endfunction

   function automatic void add_tag(logic [31:0] tag);
      add_le(tag, 4);
   endfunction

   function automatic void add_head();
      add_tag(TAG_RIFF);
      add_le($urandom, 4);
      add_tag(TAG_WAVE);
   endfunction

   // fmt chunk of any size: the 16-byte body is cut or padded out to fit
   function automatic void add_fmt(int size, logic [15:0] ch, logic [31:0] rate,
                                   logic [15:0] bits);
      logic [127:0] packed_body;
      packed_body = {bits, 16'(ch * 2), 32'(rate * ch * 2), rate, ch, 16'd1};
      add_tag(TAG_FMT);
      add_le(size, 4);
      for (int i = 0; i < size; i++)
         file_q.push_back(i < 16 ? packed_body[8*i+:8] : 8'($urandom));
      if (size % 2) file_q.push_back(8'($urandom));
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void add_data(int ch, int frames, int partial, bit pad);
      int size;
      size = frames * ch * 2 + partial;
      add_tag(TAG_DATA);
      add_le(size, 4);
      for (int i = 0; i < frames * ch; i++) add_le(pick_sample(), 2);
      for (int i = 0; i < partial; i++) file_q.push_back(8'($urandom));
      if (pad && size % 2) file_q.push_back(8'($urandom));
   endfunction

   function automatic void add_other(int size);
      add_tag(32'h5453_494C);
      add_le(size, 4);
      for (int i = 0; i < size + (size % 2); i++) file_q.push_back(8'($urandom));
   endfunction

   task automatic test_header_errors();
      add_tag(32'h5846_4952);                     // wrong first tag
      send_file();
      file_q.push_back("R"); file_q.push_back("I"); // ends inside the RIFF tag
      send_file();
      add_tag(TAG_RIFF); add_le(0, 4); add_tag(32'h5856_4157);
      add_le(32'hFFFF_FFFF, 4);                   // bytes after an error are ignored
      send_file();
      add_tag(TAG_RIFF); add_le(0, 2);            // ends inside the RIFF size
      send_file();
      add_head(); add_tag(TAG_DATA); add_le(5, 2); // ends inside a chunk size
      send_file();
      add_head(); add_data(1, 1, 0, 1);           // data with no fmt
      send_file();
      add_head();                                 // nothing but the header
      send_file();
   endtask

   task automatic test_format_checks();
      add_head(); add_fmt(16, 1, 4, 8); add_data(1, 0, 0, 1);
      send_file();
      add_head(); add_fmt(16, 0, 4, 16); add_data(1, 0, 0, 1);
      send_file();
      add_head(); add_fmt(16, 64, 4, 16); add_data(1, 0, 0, 1);
      send_file();
      // second fmt chunk is short: channels and rate taken, bits kept
      add_head(); add_fmt(16, 1, 2, 16); add_fmt(10, 2, 6, 8); add_fmt(0, 0, 0, 0);
      add_data(2, 7, 0, 1);
      send_file();
      add_head(); add_fmt(18, 2, 4, 16); add_data(2, 3, 0, 1);
      file_q = file_q[0:file_q.size() - 4];       // truncated inside the data
      send_file();
   endtask

   task automatic test_pad_and_windows();
      add_head(); add_other(3); add_fmt(16, 2, 4, 16);
      add_data(2, 6, 3, 0);                       // odd size, pad byte missing at end
      send_file();
      add_head(); add_fmt(16, 1, 0, 16); add_data(1, 5, 1, 1);
      add_data(1, 3, 0, 1);                       // peaks carry over, count restarts
      send_file();
      add_head(); add_fmt(16, 3, 1, 16); add_data(3, 21, 5, 1);
      file_q.push_back("d"); file_q.push_back("a"); // ends inside a chunk id
      send_file();
   endtask

   task automatic test_scale_extremes();
      write_scale(8'd0);
      add_head(); add_fmt(16, 2, 2, 16); add_data(2, 4, 0, 1);
      send_file();
      write_scale(8'd255);
      add_head(); add_fmt(16, 2, 2, 16); add_data(2, 4, 0, 1);
      send_file();
   endtask

   task automatic test_random_files();
      int sent;
      int ch;
      sent = 0;
      while (sent < 150) begin
         if ($urandom_range(0, 5) == 0) write_scale(8'($urandom));
         ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65) : $urandom_range(1, 3);
         add_head();
         if ($urandom_range(0, 3) == 0) add_other($urandom_range(0, 5));
         if ($urandom_range(0, 9) != 0)
            add_fmt($urandom_range(0, 5) == 0 ? $urandom_range(0, 20) : 16, ch,
                    $urandom_range(0, 12),
                    $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'd16);
         add_data(ch == 0 ? 1 : ch, $urandom_range(0, 12), $urandom_range(0, 5),
                  $urandom_range(0, 1));
         if ($urandom_range(0, 3) == 0) add_data(ch == 0 ? 1 : ch, $urandom_range(0, 6), 0, 1);
         if ($urandom_range(0, 7) == 0) file_q[$urandom_range(0, 11)] = 8'($urandom);
         if ($urandom_range(0, 7) == 0) file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
         // now and then a run of raw noise
         if ($urandom_range(0, 9) == 0) begin
            file_q.delete();
            repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
         end
         sent += file_q.size();
         send_file();
      end
   endtask

   initial begin
      m_scale = SCALE_RESET;
      clear_meter();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_header_errors();
      test_format_checks();
      test_pad_and_windows();
      test_scale_extremes();
      test_random_files();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (peak_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && peak_q.size() == 0) begin
         $display("wav_stream_peak_meter_core_tb OK");
      end else begin
         $display("wav_stream_peak_meter_core_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("wav_stream_peak_meter_core_tb NOT OK");
      $finish;
   end

endmodule
